// ----- hw/rtl/config_list_tokenizer_top_assert.svh -----
// assertion macros for the config list tokenizer
// expects clk and arst_n in the scope of the including module
`ifndef CONFIG_LIST_TOKENIZER_TOP_ASSERT_SVH
`define CONFIG_LIST_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/clt_pkg.sv -----
// shared types, constants and character classes for the config list tokenizer
// no dependencies
package clt_pkg;

	localparam int unsigned FIFO_DEPTH   = 4;
	localparam int unsigned KW_ANY_LEN   = 3;
	localparam int unsigned KW_FIRST_LEN = 5;
	localparam logic [2:0]  LEN_MAX      = 3'd7;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] HIGH_BYTE = 8'h80;

	typedef enum logic [2:0] {
		M_IDLE   = 3'd0,
		M_NUM    = 3'd1,
		M_IDENT  = 3'd2,
		M_QUOTED = 3'd3,
		M_QSEEN  = 3'd4
	} scan_mode_t;

	typedef enum logic [3:0] {
		T_END    = 4'd0,
		T_COMMA  = 4'd1,
		T_LPAREN = 4'd2,
		T_RPAREN = 4'd3,
		T_NAME   = 4'd4,
		T_NUMBER = 4'd5,
		T_ANY    = 4'd6,
		T_FIRST  = 4'd7,
		T_JUNK   = 4'd8
	} token_type_t;

	typedef struct packed {
		token_type_t token_type;
		logic [7:0]  text_byte;
		logic        byte_valid;
		logic        token_done;
	} result_t;

	typedef struct packed {
		result_t res;
		logic    last;
	} beat_t;

	// results produced by one scanned item, slot0 goes out first
	typedef struct packed {
		logic [1:0] n;
		beat_t      slot0;
		beat_t      slot1;
	} wr_req_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_start(input logic [7:0] c);
		return is_alpha(c) || (c >= HIGH_BYTE) || (c == CH_UNDER);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return is_start(c) || is_dig(c) || (c == CH_DOLLAR);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
			(c == CH_FF) || (c == CH_VT);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic [7:0] kw_any_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0:    r = 8'h61; // a
			3'd1:    r = 8'h6E; // n
			3'd2:    r = 8'h79; // y
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_first_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0:    r = 8'h66; // f
			3'd1:    r = 8'h69; // i
			3'd2:    r = 8'h72; // r
			3'd3:    r = 8'h73; // s
			3'd4:    r = 8'h74; // t
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/clt_scan.sv -----
// scanner state and per-byte decode: turns one registered item into up to two results
// depends on clt_pkg
module clt_scan import clt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output wr_req_t    wr
);

	scan_mode_t mode_q, mode_d;
	logic       any_q, any_d;
	logic       first_q, first_d;
	logic [2:0] len_q, len_d;

	logic [7:0]  lc;
	result_t     close_r, idle_r, byte_r, end_r, pre_r, post_r;
	logic        idle_v, pre_v, post_v;
	scan_mode_t  idle_mode;
	logic        idle_ident;
	logic        trk_any, trk_first;
	logic [2:0]  trk_len;
	token_type_t ident_type;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			any_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 3'd0;
		end else if (go) begin
			mode_q  <= mode_d;
			any_q   <= any_d;
			first_q <= first_d;
			len_q   <= len_d;
		end
	end

	always_comb begin
		lc = to_lower(in_byte);

		trk_any   = any_q && (len_q < 3'(KW_ANY_LEN)) && (lc == kw_any_char(len_q));
		trk_first = first_q && (len_q < 3'(KW_FIRST_LEN)) && (lc == kw_first_char(len_q));
		trk_len   = (len_q == LEN_MAX) ? LEN_MAX : len_q + 3'd1;

		if (any_q && len_q == 3'(KW_ANY_LEN))
			ident_type = T_ANY;
		else if (first_q && len_q == 3'(KW_FIRST_LEN))
			ident_type = T_FIRST;
		else
			ident_type = T_NAME;

		// closing result for whatever token is open
		close_r = '{token_type: T_NAME, text_byte: 8'h00, byte_valid: 1'b0, token_done: 1'b1};
		case (mode_q)
			M_NUM:   close_r.token_type = T_NUMBER;
			M_IDENT: close_r.token_type = ident_type;
			default: close_r.token_type = T_NAME;
		endcase

		byte_r = '{token_type: T_END, text_byte: in_byte, byte_valid: 1'b1, token_done: 1'b0};
		end_r  = '{token_type: T_END, text_byte: 8'h00, byte_valid: 1'b0, token_done: 1'b1};

		// byte taken between tokens
		idle_v     = 1'b1;
		idle_mode  = M_IDLE;
		idle_ident = 1'b0;
		idle_r     = '{token_type: T_JUNK, text_byte: 8'h00, byte_valid: 1'b0, token_done: 1'b1};
		if (is_ws(in_byte)) begin
			idle_v = 1'b0;
		end else if (in_byte == CH_COMMA) begin
			idle_r.token_type = T_COMMA;
		end else if (in_byte == CH_LPAREN) begin
			idle_r.token_type = T_LPAREN;
		end else if (in_byte == CH_RPAREN) begin
			idle_r.token_type = T_RPAREN;
		end else if (in_byte == CH_STAR) begin
			idle_r = '{token_type: T_NAME, text_byte: in_byte, byte_valid: 1'b1,
				token_done: 1'b1};
		end else if (in_byte == CH_QUOTE) begin
			idle_v    = 1'b0;
			idle_mode = M_QUOTED;
		end else if (is_dig(in_byte)) begin
			idle_r    = byte_r;
			idle_mode = M_NUM;
		end else if (is_start(in_byte)) begin
			idle_r     = byte_r;
			idle_mode  = M_IDENT;
			idle_ident = 1'b1;
		end

		pre_v   = 1'b0;
		pre_r   = close_r;
		post_v  = 1'b0;
		post_r  = byte_r;
		mode_d  = mode_q;
		any_d   = any_q;
		first_d = first_q;
		len_d   = len_q;

		if (end_of_input) begin
			pre_v   = (mode_q != M_IDLE);
			post_v  = 1'b1;
			post_r  = end_r;
			mode_d  = M_IDLE;
			any_d   = 1'b0;
			first_d = 1'b0;
			len_d   = 3'd0;
		end else begin
			case (mode_q)
				M_NUM: begin
					if (is_dig(in_byte)) begin
						post_v = 1'b1;
					end else begin
						pre_v  = 1'b1;
						post_v = idle_v;
						post_r = idle_r;
						mode_d = idle_mode;
					end
				end
				M_IDENT: begin
					if (is_cont(in_byte)) begin
						post_v  = 1'b1;
						any_d   = trk_any;
						first_d = trk_first;
						len_d   = trk_len;
					end else begin
						pre_v  = 1'b1;
						post_v = idle_v;
						post_r = idle_r;
						mode_d = idle_mode;
					end
				end
				M_QUOTED: begin
					if (in_byte == CH_QUOTE)
						mode_d = M_QSEEN;
					else
						post_v = 1'b1;
				end
				M_QSEEN: begin
					if (in_byte == CH_QUOTE) begin
						mode_d = M_QUOTED;
						post_v = 1'b1;
					end else begin
						pre_v  = 1'b1;
						post_v = idle_v;
						post_r = idle_r;
						mode_d = idle_mode;
					end
				end
				default: begin
					post_v = idle_v;
					post_r = idle_r;
					mode_d = idle_mode;
				end
			endcase
			// a new identifier restarts keyword tracking with its first byte
			if (idle_ident && mode_d == M_IDENT && mode_q != M_IDENT) begin
				any_d   = (lc == kw_any_char(3'd0));
				first_d = (lc == kw_first_char(3'd0));
				len_d   = 3'd1;
			end
		end
	end

	always_comb begin
		wr.n          = 2'(pre_v) + 2'(post_v);
		wr.slot0.res  = pre_v ? pre_r : post_r;
		wr.slot0.last = !(pre_v && post_v);
		wr.slot1.res  = post_r;
		wr.slot1.last = 1'b1;
	end

endmodule

// ----- hw/rtl/clt_out_fifo.sv -----
// result queue: takes up to two beats per cycle while go is high, hands out one per cycle while out_ready is high
// depends on clt_pkg
module clt_out_fifo import clt_pkg::*; (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  wr_req_t                            wr,
	output logic [$clog2(FIFO_DEPTH+1)-1:0]    count,
	output logic                               out_valid,
	input  logic                               out_ready,
	output beat_t                              out_beat
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	beat_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        n_push;
	logic              pop;

	assign n_push    = go ? wr.n : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_beat  = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_ptr_q] <= wr.slot0;
		if (n_push == 2'd2)
			mem_q[wr_ptr_q + PTR_W'(1)] <= wr.slot1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

// ----- hw/rtl/config_list_tokenizer_top.sv -----
// top level of the config list tokenizer: input stage, scanner and result queue
// depends on clt_pkg, clt_scan, clt_out_fifo and config_list_tokenizer_top_assert.svh
//
// input stream: one beat per text byte in s_tdata, s_tuser high marks end of text
// (the byte is then ignored). output stream: one beat per result, tdata carries the
// text byte, tuser the token type and the byte/close flags, tlast the last result of
// one input beat. an input beat causes zero, one or two output beats.
// a beat is held in the input register, then decoded and written to
// a four-entry result queue; the first result shows on m_tvalid once the queue
// holds it. the scanner takes one byte per cycle as long as the
// queue holds at most two results, so the input side runs at one beat per cycle
// while the output drains; bytes that close one token and open another give two
// output beats and run at the output rate of one beat per cycle.
// when m_tready is low the queue fills and s_tready drops once the input register
// holds a beat that cannot be written; nothing is lost or repeated.
// reset puts the scanner between tokens with an empty queue; after an end beat the
// scanner is idle again and a new text may follow.
module config_list_tokenizer_top import clt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic [0:0] s_tuser,  // [0] end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] text_byte
	output logic [5:0] m_tuser,  // [3:0] token_type, [4] byte_valid, [5] token_done
	output logic       m_tlast   // last_of_run
);

	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eoi_s1;
	logic             go;
	logic [CNT_W-1:0] fifo_count;
	wr_req_t          wr;
	beat_t            out_beat;

	// room for the worst case of two results
	assign go       = valid_s1 && (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tuser[0];
		end
	end

	clt_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.wr           (wr)
	);

	clt_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.wr        (wr),
		.count     (fifo_count),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (out_beat)
	);

	assign m_tdata = out_beat.res.text_byte;
	assign m_tuser = {out_beat.res.token_done, out_beat.res.byte_valid,
		out_beat.res.token_type};
	assign m_tlast = out_beat.last;

	`include "config_list_tokenizer_top_assert.svh"

	`CLT_ASSERT_IMPLIES(a_fifo_bound, 1'b1, fifo_count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`CLT_ASSERT_IMPLIES(a_open_has_byte, m_tvalid && !m_tuser[5], m_tuser[4], "non-closing result without a text byte")
	`CLT_ASSERT_IMPLIES(a_end_is_last, m_tvalid && m_tuser[5] && (m_tuser[3:0] == T_END), m_tlast, "end token not last of its run")
	`CLT_ASSERT_NEXT(a_end_idles, go && eoi_s1, u_scan.mode_q == M_IDLE, "scanner not idle after end beat")

endmodule
